FILE: design/i2cees_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cees_pkg
// Types and codes shared by the I2C EEPROM transaction sequencer files.
// ----------------------------------------------------------------------------
package i2cees_pkg;

   // Item kinds on the request channel
   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_WRITE = 2'd2,
      MODE_EVENT = 2'd3
   } mode_type;

   // Bus events reported by the I2C master
   typedef enum logic [2:0] {
      EV_MODE_SELECT  = 3'd0,
      EV_TX_SELECTED  = 3'd1,
      EV_RX_SELECTED  = 3'd2,
      EV_BYTE_SENDING = 3'd3,
      EV_BYTE_SENT    = 3'd4,
      EV_BYTE_RECV    = 3'd5,
      EV_OTHER        = 3'd6
   } event_type;

   // Running transaction
   typedef enum logic [1:0] {
      OP_IDLE  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   localparam int unsigned CountWidth = 9;
   localparam int unsigned ByteWidth  = 8;

   // One request item
   typedef struct packed {
      logic [1:0]            mode;
      logic [2:0]            bus_event;
      logic [ByteWidth-1:0]  slave_address;
      logic [ByteWidth-1:0]  word_address;
      logic [CountWidth-1:0] byte_count;
      logic [ByteWidth-1:0]  load_byte;
      logic [ByteWidth-1:0]  received_byte;
   } req_item_type;

   // Result flags and read data (tx_value travels on its own)
   typedef struct packed {
      logic                 ack_enable;
      logic                 ack_disable;
      logic                 start_condition;
      logic                 stop_condition;
      logic                 send_address;
      logic                 address_read;
      logic                 send_byte;
      logic                 read_valid;
      logic [ByteWidth-1:0] read_data;
      logic                 done_res;
      logic                 request_error;
   } rsp_flags_type;

   // Handshake between input stage and core
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

endpackage

FILE: design/i2cees_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cees_req_if / i2cees_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface i2cees_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [2:0] bus_event;
   logic [7:0] slave_address;
   logic [7:0] word_address;
   logic [8:0] byte_count;
   logic [7:0] load_byte;
   logic [7:0] received_byte;

   modport source (output valid, mode, bus_event, slave_address, word_address,
                   byte_count, load_byte, received_byte, input ready);
   modport sink (input valid, mode, bus_event, slave_address, word_address,
                 byte_count, load_byte, received_byte, output ready);
endinterface

interface i2cees_rsp_if;
   logic       valid;
   logic       ready;
   logic       ack_enable;
   logic       ack_disable;
   logic       start_condition;
   logic       stop_condition;
   logic       send_address;
   logic       address_read;
   logic       send_byte;
   logic [7:0] tx_value;
   logic       read_valid;
   logic [7:0] read_data;
   logic       done_res;
   logic       request_error;

   modport source (output valid, ack_enable, ack_disable, start_condition,
                   stop_condition, send_address, address_read, send_byte,
                   tx_value, read_valid, read_data, done_res, request_error,
                   input ready);
   modport sink (input valid, ack_enable, ack_disable, start_condition,
                 stop_condition, send_address, address_read, send_byte,
                 tx_value, read_valid, read_data, done_res, request_error,
                 output ready);
endinterface

FILE: design/i2cees_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cees_in_stage
// Input register: captures one request item and holds it until the core
// takes it.
// ----------------------------------------------------------------------------
module i2cees_in_stage
   import i2cees_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   i2cees_req_if.sink        req_chan,
   input  logic              take,
   output stage_type         stage
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         load;

   // Room when empty or when the held item leaves this cycle
   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;
   assign valid_in       = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= '{mode:          req_chan.mode,
                      bus_event:     req_chan.bus_event,
                      slave_address: req_chan.slave_address,
                      word_address:  req_chan.word_address,
                      byte_count:    req_chan.byte_count,
                      load_byte:     req_chan.load_byte,
                      received_byte: req_chan.received_byte};
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

FILE: design/i2cees_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cees_core
// Transaction state, page buffer and result register. Decodes one item per
// cycle against the current state while no result stalls, and registers it.
// ----------------------------------------------------------------------------
module i2cees_core
   import i2cees_pkg::*;
#(
   parameter int unsigned PAGE_BYTES = 8,
   parameter int unsigned MAX_READ   = 256
)
(
   input  logic       clock,
   input  logic       reset,
   input  stage_type  stage,
   output logic       take,
   i2cees_rsp_if.source rsp_chan
);

   localparam int unsigned PtrWidth = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
   localparam logic [PtrWidth-1:0]   PtrLast   = PtrWidth'(PAGE_BYTES - 1);
   localparam logic [CountWidth-1:0] PageLimit = CountWidth'(PAGE_BYTES);
   localparam logic [CountWidth-1:0] ReadLimit = CountWidth'(MAX_READ);

   // Transaction state
   op_type                op_ff, op_in;
   logic                  phase_ff, phase_in;
   logic [ByteWidth-1:0]  dev_ff, dev_in;
   logic [ByteWidth-1:0]  mem_ff, mem_in;
   logic [CountWidth-1:0] len_ff, len_in;
   logic [CountWidth-1:0] idx_ff, idx_in;
   logic [PtrWidth-1:0]   lp_ff, lp_in;

   // Page buffer
   logic [ByteWidth-1:0]  page_buffer [PAGE_BYTES];
   logic                  buf_we;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_flags_type         flags_ff, flags_in;
   logic [ByteWidth-1:0]  tx_ff, tx_in;
   logic                  use_buf;

   req_item_type          item;
   logic [CountWidth-1:0] idx_next;
   logic [CountWidth:0]   idx_after;
   logic [CountWidth-1:0] limit;

   assign item      = stage.item;
   assign take      = stage.valid && (!rsp_valid_ff || rsp_chan.ready);
   assign idx_next  = idx_ff + CountWidth'(1);
   assign idx_after = {1'b0, idx_next} + (CountWidth + 1)'(1);
   assign limit     = (mode_type'(item.mode) == MODE_READ) ? ReadLimit : PageLimit;

   // Decode of one item against the current state
   always_comb begin
      op_in    = op_ff;
      phase_in = phase_ff;
      dev_in   = dev_ff;
      mem_in   = mem_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      lp_in    = lp_ff;
      buf_we   = 1'b0;
      flags_in = '0;
      tx_in    = '0;
      use_buf  = 1'b0;

      unique case (mode_type'(item.mode))
         MODE_LOAD: begin
            buf_we = 1'b1;
            lp_in  = (lp_ff == PtrLast) ? '0 : lp_ff + PtrWidth'(1);
         end
         MODE_READ, MODE_WRITE: begin
            if (item.byte_count == '0 || item.byte_count > limit) begin
               flags_in.request_error = 1'b1;
            end else begin
               op_in    = (mode_type'(item.mode) == MODE_READ) ? OP_READ : OP_WRITE;
               phase_in = 1'b0;
               dev_in   = item.slave_address;
               mem_in   = item.word_address;
               len_in   = item.byte_count;
               idx_in   = '0;
               if (mode_type'(item.mode) == MODE_WRITE) begin
                  lp_in = '0;
               end
               flags_in.start_condition = 1'b1;
            end
         end
         MODE_EVENT: begin
            unique case (event_type'(item.bus_event))
               EV_MODE_SELECT: begin
                  flags_in.ack_enable = 1'b1;
                  if (op_ff == OP_READ || op_ff == OP_WRITE) begin
                     flags_in.send_address = 1'b1;
                     flags_in.address_read = (op_ff == OP_READ) && phase_ff;
                     tx_in                 = dev_ff;
                  end
               end
               EV_RX_SELECTED: begin
                  if (op_ff == OP_READ && len_ff == CountWidth'(1)) begin
                     flags_in.ack_disable    = 1'b1;
                     flags_in.stop_condition = 1'b1;
                  end
               end
               EV_BYTE_SENDING: begin
                  // Word address first, then buffered data on a write
                  if ((op_ff == OP_READ || op_ff == OP_WRITE) && !phase_ff) begin
                     flags_in.send_byte = 1'b1;
                     tx_in              = mem_ff;
                     phase_in           = 1'b1;
                  end else if (op_ff == OP_WRITE && idx_ff < len_ff) begin
                     flags_in.send_byte = 1'b1;
                     use_buf            = idx_ff < PageLimit;
                     idx_in             = idx_next;
                  end
               end
               EV_BYTE_SENT: begin
                  if (op_ff == OP_READ) begin
                     flags_in.start_condition = 1'b1;
                  end else if (op_ff == OP_WRITE && idx_ff == len_ff) begin
                     flags_in.stop_condition = 1'b1;
                     flags_in.done_res       = 1'b1;
                     op_in                   = OP_IDLE;
                  end
               end
               EV_BYTE_RECV: begin
                  if (op_ff == OP_READ) begin
                     flags_in.read_valid = 1'b1;
                     flags_in.read_data  = item.received_byte;
                     idx_in              = idx_next;
                     // NACK and STOP ahead of the last byte, done on it
                     if (idx_after == {1'b0, len_ff}) begin
                        flags_in.ack_disable    = 1'b1;
                        flags_in.stop_condition = 1'b1;
                     end else if (idx_next == len_ff) begin
                        flags_in.done_res = 1'b1;
                        op_in             = OP_IDLE;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_chan.ready);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         op_ff        <= OP_IDLE;
         phase_ff     <= 1'b0;
         dev_ff       <= '0;
         mem_ff       <= '0;
         len_ff       <= '0;
         idx_ff       <= '0;
         lp_ff        <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            op_ff    <= op_in;
            phase_ff <= phase_in;
            dev_ff   <= dev_in;
            mem_ff   <= mem_in;
            len_ff   <= len_in;
            idx_ff   <= idx_in;
            lp_ff    <= lp_in;
         end
      end
   end

   // Page buffer write, and registered read into the tx result field
   always_ff @(posedge clock) begin
      if (take && buf_we) begin
         page_buffer[lp_ff] <= item.load_byte;
      end
      if (take) begin
         flags_ff <= flags_in;
         tx_ff    <= use_buf ? page_buffer[idx_ff[PtrWidth-1:0]] : tx_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.ack_enable      = flags_ff.ack_enable;
   assign rsp_chan.ack_disable     = flags_ff.ack_disable;
   assign rsp_chan.start_condition = flags_ff.start_condition;
   assign rsp_chan.stop_condition  = flags_ff.stop_condition;
   assign rsp_chan.send_address    = flags_ff.send_address;
   assign rsp_chan.address_read    = flags_ff.address_read;
   assign rsp_chan.send_byte       = flags_ff.send_byte;
   assign rsp_chan.tx_value        = tx_ff;
   assign rsp_chan.read_valid      = flags_ff.read_valid;
   assign rsp_chan.read_data       = flags_ff.read_data;
   assign rsp_chan.done_res        = flags_ff.done_res;
   assign rsp_chan.request_error   = flags_ff.request_error;

endmodule

FILE: design/i2c_eeprom_transaction_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_eeprom_transaction_sequencer_unit
// Sequences random reads and page writes to a serial EEPROM through an I2C
// master, one command set per request item.
//
//   channel   | dir | handshake    | payload
//   ----------+-----+--------------+-------------------------------------
//   req_chan  | in  | valid/ready  | mode, bus_event, addresses, count, data
//   rsp_chan  | out | valid/ready  | command flags, tx_value, read data
//
// One item accepted per cycle while the result side does not stall; its
// result goes through the input register, then decode into the result
// register. Throughput is one item per cycle when no result stalls, with a
// combinational decode and one write / one read port on the page buffer.
// Reset is synchronous; the page buffer is not cleared.
// A stalled result holds in the result register while the input register
// still takes one more item.
// ----------------------------------------------------------------------------
module i2c_eeprom_transaction_sequencer_unit
   import i2cees_pkg::*;
#(
   parameter int unsigned PAGE_BYTES = 8,
   parameter int unsigned MAX_READ   = 256
)
(
   input  logic         clock,
   input  logic         reset,
   i2cees_req_if.sink   req_chan,
   i2cees_rsp_if.source rsp_chan
);

   stage_type stage;
   logic      take;

   // Input register
   i2cees_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .stage    (stage)
   );

   // Decode, state and result register
   i2cees_core #(
      .PAGE_BYTES (PAGE_BYTES),
      .MAX_READ   (MAX_READ)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage),
      .take     (take),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: design/i2cees_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cees_checker
// Port-level checks on the result channel of the sequencer.
// ----------------------------------------------------------------------------
module i2cees_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       ack_enable,
   input logic       start_condition,
   input logic       stop_condition,
   input logic       send_address,
   input logic       address_read,
   input logic       send_byte,
   input logic [7:0] tx_value,
   input logic       read_valid,
   input logic       done_res,
   input logic       request_error
);

   // A stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(tx_value)
         && $stable(done_res) && $stable(read_valid))
      else $error("stalled result item changed");

   // A rejected start raises no start, ack, address, transmit, read or done flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && request_error |-> !start_condition && !ack_enable
         && !send_address && !send_byte && !read_valid && !done_res)
      else $error("request error with commands");

   // Direction only comes with an address phase
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && address_read |-> send_address)
      else $error("address_read without send_address");

   // A finishing item never starts or transmits anything
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> !start_condition && !send_byte && !send_address)
      else $error("done with start or transmit");

   // A received byte is never paired with a transmit or a STOP and done
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && read_valid |-> !send_byte && !send_address
         && !(stop_condition && done_res))
      else $error("read data with transmit command");

endmodule

bind i2c_eeprom_transaction_sequencer_unit i2cees_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .ack_enable      (rsp_chan.ack_enable),
   .start_condition (rsp_chan.start_condition),
   .stop_condition  (rsp_chan.stop_condition),
   .send_address    (rsp_chan.send_address),
   .address_read    (rsp_chan.address_read),
   .send_byte       (rsp_chan.send_byte),
   .tx_value        (rsp_chan.tx_value),
   .read_valid      (rsp_chan.read_valid),
   .done_res        (rsp_chan.done_res),
   .request_error   (rsp_chan.request_error)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the I2C EEPROM transaction sequencer. Directed
// items fill the page, hit the length limits and idle events, and run a
// single-byte read. Random traffic follows with mostly well-formed random
// reads and page writes, plus cut-short transactions and noise. Both
// handshake sides idle at random. A scoreboard class models the sequencer
// and checks every command set in order.
// ----------------------------------------------------------------------------
module tb_top;
   import i2cees_pkg::*;

   localparam int unsigned PAGE_DEPTH     = 8;
   localparam int unsigned MAX_READ_LEN   = 256;
   localparam int unsigned ITEM_TARGET    = 1350;
   localparam int unsigned QUIET_FROM     = 1150;
   localparam int unsigned HOLD_AT        = 300;
   localparam int unsigned DRAIN_AT       = 700;
   localparam int unsigned HOLD_CYCLES    = 64;
   localparam int unsigned TAIL_CYCLES    = 8;
   localparam int unsigned WATCHDOG_LIMIT = 1000;

   // Commands and read data produced for one item
   typedef struct packed {
      rsp_flags_type flags;
      logic [7:0]    tx_value;
   } eeprom_cmd_type;

   // -------------------------------------------------------------------------
   // Scoreboard: tracks the sequencer state and the pending command sets
   // -------------------------------------------------------------------------
   class eeprom_cmd_scoreboard;
      op_type         op;
      bit             addr_sent;   // word address already on the bus
      logic [7:0]     dev_addr;
      logic [7:0]     word_addr;
      logic [8:0]     xfer_len;
      logic [8:0]     xfer_idx;
      logic [7:0]     page_data [PAGE_DEPTH];
      logic [2:0]     fill_ptr;
      eeprom_cmd_type expected_cmds [$];
      int unsigned    errors;
      int unsigned    checked;
      int unsigned    finished;
      int unsigned    rejected;

      function new();
         op        = OP_IDLE;
         addr_sent = 1'b0;
         dev_addr  = '0;
         word_addr = '0;
         xfer_len  = '0;
         xfer_idx  = '0;
         fill_ptr  = '0;
         foreach (page_data[i]) page_data[i] = '0;
         errors    = 0;
         checked   = 0;
         finished  = 0;
         rejected  = 0;
      endfunction

      // Next command set for one accepted item; updates the state
      function eeprom_cmd_type predict_commands(req_item_type it);
         eeprom_cmd_type c;
         int unsigned    limit;
         c = '0;
         case (it.mode)
            MODE_LOAD: begin
               // 3-bit pointer wraps after a full page
               page_data[fill_ptr] = it.load_byte;
               fill_ptr = fill_ptr + 3'd1;
            end
            MODE_READ, MODE_WRITE: begin
               limit = (it.mode == MODE_READ) ? MAX_READ_LEN : PAGE_DEPTH;
               if (it.byte_count == 0 || it.byte_count > limit) begin
                  c.flags.request_error = 1'b1;
                  rejected++;
               end else begin
                  // a new start replaces whatever is running
                  op        = (it.mode == MODE_READ) ? OP_READ : OP_WRITE;
                  addr_sent = 1'b0;
                  dev_addr  = it.slave_address;
                  word_addr = it.word_address;
                  xfer_len  = it.byte_count;
                  xfer_idx  = '0;
                  if (it.mode == MODE_WRITE) fill_ptr = '0;
                  c.flags.start_condition = 1'b1;
               end
            end
            default: begin
               case (it.bus_event)
                  EV_MODE_SELECT: begin
                     c.flags.ack_enable = 1'b1;
                     if (op != OP_IDLE) begin
                        c.flags.send_address = 1'b1;
                        c.tx_value           = dev_addr;
                        c.flags.address_read = (op == OP_READ) && addr_sent;
                     end
                  end
                  EV_RX_SELECTED: begin
                     if (op == OP_READ && xfer_len == 1) begin
                        c.flags.ack_disable    = 1'b1;
                        c.flags.stop_condition = 1'b1;
                     end
                  end
                  EV_BYTE_SENDING: begin
                     if (op != OP_IDLE && !addr_sent) begin
                        c.flags.send_byte = 1'b1;
                        c.tx_value        = word_addr;
                        addr_sent         = 1'b1;
                     end else if (op == OP_WRITE && xfer_idx < xfer_len) begin
                        c.flags.send_byte = 1'b1;
                        c.tx_value        = page_data[xfer_idx[2:0]];
                        xfer_idx          = xfer_idx + 9'd1;
                     end
                  end
                  EV_BYTE_SENT: begin
                     if (op == OP_READ) begin
                        c.flags.start_condition = 1'b1;
                     end else if (op == OP_WRITE && xfer_idx == xfer_len) begin
                        c.flags.stop_condition = 1'b1;
                        c.flags.done_res       = 1'b1;
                        op                     = OP_IDLE;
                        finished++;
                     end
                  end
                  EV_BYTE_RECV: begin
                     if (op == OP_READ) begin
                        c.flags.read_valid = 1'b1;
                        c.flags.read_data  = it.received_byte;
                        xfer_idx           = xfer_idx + 9'd1;
                        // NACK and STOP go out ahead of the last byte
                        if (xfer_idx + 1 == xfer_len) begin
                           c.flags.ack_disable    = 1'b1;
                           c.flags.stop_condition = 1'b1;
                        end else if (xfer_idx == xfer_len) begin
                           c.flags.done_res = 1'b1;
                           op               = OP_IDLE;
                           finished++;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         endcase
         return c;
      endfunction

      function void note_request(req_item_type it);
         expected_cmds.push_back(predict_commands(it));
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
         if (seen !== want) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            errors++;
         end
      endfunction

      function void check_command(eeprom_cmd_type seen);
         eeprom_cmd_type want;
         if (expected_cmds.size() == 0) begin
            $error("command set received with none pending");
            errors++;
            return;
         end
         want = expected_cmds.pop_front();
         checked++;
         compare_field("ack_enable", want.flags.ack_enable, seen.flags.ack_enable);
         compare_field("ack_disable", want.flags.ack_disable, seen.flags.ack_disable);
         compare_field("start_condition", want.flags.start_condition,
                       seen.flags.start_condition);
         compare_field("stop_condition", want.flags.stop_condition,
                       seen.flags.stop_condition);
         compare_field("send_address", want.flags.send_address, seen.flags.send_address);
         compare_field("address_read", want.flags.address_read, seen.flags.address_read);
         compare_field("send_byte", want.flags.send_byte, seen.flags.send_byte);
         compare_field("tx_value", want.tx_value, seen.tx_value);
         compare_field("read_valid", want.flags.read_valid, seen.flags.read_valid);
         compare_field("read_data", want.flags.read_data, seen.flags.read_data);
         compare_field("done_res", want.flags.done_res, seen.flags.done_res);
         compare_field("request_error", want.flags.request_error,
                       seen.flags.request_error);
      endfunction
   endclass

   logic clock;
   logic reset;

   i2cees_req_if req_bus ();
   i2cees_rsp_if rsp_bus ();

   i2c_eeprom_transaction_sequencer_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   eeprom_cmd_scoreboard sb;
   req_item_type         plan [$];
   int unsigned          items_sent;
   bit                   quiet;
   bit                   hold_request;
   int unsigned          idle_cycles;

   // 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Item builders: unused fields get random values
   // -------------------------------------------------------------------------
   function automatic req_item_type rand_item(logic [1:0] mode, logic [2:0] ev);
      req_item_type it;
      it.mode          = mode;
      it.bus_event     = ev;
      it.slave_address = 8'($urandom);
      it.word_address  = 8'($urandom);
      it.byte_count    = 9'($urandom);
      it.load_byte     = 8'($urandom);
      it.received_byte = 8'($urandom);
      return it;
   endfunction

   function automatic void plan_event(logic [2:0] ev);
      plan.push_back(rand_item(MODE_EVENT, ev));
   endfunction

   function automatic void plan_load(logic [7:0] data);
      req_item_type it;
      it           = rand_item(MODE_LOAD, 3'($urandom));
      it.load_byte = data;
      plan.push_back(it);
   endfunction

   function automatic void plan_start(logic [1:0] mode, int unsigned count);
      req_item_type it;
      it            = rand_item(mode, 3'($urandom));
      it.byte_count = 9'(count);
      plan.push_back(it);
   endfunction

   // Random read: address phase, repeated START, then the data bytes
   function automatic void plan_read(int unsigned len);
      plan_start(MODE_READ, len);
      plan_event(EV_MODE_SELECT);
      plan_event(EV_TX_SELECTED);
      plan_event(EV_BYTE_SENDING);
      plan_event(EV_BYTE_SENT);
      plan_event(EV_MODE_SELECT);
      plan_event(EV_RX_SELECTED);
      repeat (len) plan_event(EV_BYTE_RECV);
   endfunction

   // Page write; now and then a late load overwrites a page byte mid-transfer
   function automatic void plan_write(int unsigned len);
      int unsigned loads;
      loads = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len) : len;
      plan_start(MODE_WRITE, len);
      repeat (loads) plan_load(8'($urandom));
      plan_event(EV_MODE_SELECT);
      plan_event(EV_TX_SELECTED);
      plan_event(EV_BYTE_SENDING);
      plan_event(EV_BYTE_SENT);
      repeat (len) begin
         if ($urandom_range(0, 7) == 0) plan_load(8'($urandom));
         plan_event(EV_BYTE_SENDING);
         plan_event(EV_BYTE_SENT);
      end
   endfunction

   // -------------------------------------------------------------------------
   // Request driver
   // -------------------------------------------------------------------------
   task automatic send_item(req_item_type it);
      req_bus.valid         <= 1'b1;
      req_bus.mode          <= it.mode;
      req_bus.bus_event     <= it.bus_event;
      req_bus.slave_address <= it.slave_address;
      req_bus.word_address  <= it.word_address;
      req_bus.byte_count    <= it.byte_count;
      req_bus.load_byte     <= it.load_byte;
      req_bus.received_byte <= it.received_byte;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      items_sent++;
   endtask

   task automatic issue_plan();
      foreach (plan[i]) begin
         if (!quiet && $urandom_range(0, 5) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         send_item(plan[i]);
      end
      plan.delete();
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_cmds.size() != 0);
   endtask

   // -------------------------------------------------------------------------
   // Result receiver: random stall bursts, one long hold on request
   // -------------------------------------------------------------------------
   initial begin
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Monitor and watchdog
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      req_item_type   seen_req;
      eeprom_cmd_type seen_cmd;
      if (reset === 1'b0) begin
         idle_cycles = idle_cycles + 1;
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            seen_req.mode          = req_bus.mode;
            seen_req.bus_event     = req_bus.bus_event;
            seen_req.slave_address = req_bus.slave_address;
            seen_req.word_address  = req_bus.word_address;
            seen_req.byte_count    = req_bus.byte_count;
            seen_req.load_byte     = req_bus.load_byte;
            seen_req.received_byte = req_bus.received_byte;
            sb.note_request(seen_req);
            idle_cycles = 0;
         end
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            seen_cmd.flags.ack_enable      = rsp_bus.ack_enable;
            seen_cmd.flags.ack_disable     = rsp_bus.ack_disable;
            seen_cmd.flags.start_condition = rsp_bus.start_condition;
            seen_cmd.flags.stop_condition  = rsp_bus.stop_condition;
            seen_cmd.flags.send_address    = rsp_bus.send_address;
            seen_cmd.flags.address_read    = rsp_bus.address_read;
            seen_cmd.flags.send_byte       = rsp_bus.send_byte;
            seen_cmd.flags.read_valid      = rsp_bus.read_valid;
            seen_cmd.flags.read_data       = rsp_bus.read_data;
            seen_cmd.flags.done_res        = rsp_bus.done_res;
            seen_cmd.flags.request_error   = rsp_bus.request_error;
            seen_cmd.tx_value              = rsp_bus.tx_value;
            sb.check_command(seen_cmd);
            idle_cycles = 0;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("i2c_eeprom_transaction_sequencer_unit verification failed");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      bit          first_random;
      bit          held;
      bit          drained;
      int unsigned pick;
      int unsigned len;
      req_item_type it;

      sb           = new();
      items_sent   = 0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      idle_cycles  = 0;
      first_random = 1'b1;
      held         = 1'b0;
      drained      = 1'b0;
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.mode          <= '0;
      req_bus.bus_event     <= '0;
      req_bus.slave_address <= '0;
      req_bus.word_address  <= '0;
      req_bus.byte_count    <= '0;
      req_bus.load_byte     <= '0;
      req_bus.received_byte <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole page first so no unloaded entry is ever sent
      plan_load(8'h00);
      plan_load(8'hFF);
      plan_load(8'hA5);
      plan_load(8'h5A);
      plan_load(8'h01);
      plan_load(8'h80);
      plan_load(8'h7F);
      plan_load(8'hFE);
      // events with nothing running; 7 is an unused code
      plan_event(EV_MODE_SELECT);
      plan_event(EV_BYTE_SENDING);
      plan_event(3'd7);
      // length limits
      plan_start(MODE_READ, 0);
      plan_start(MODE_READ, MAX_READ_LEN + 1);
      plan_start(MODE_WRITE, PAGE_DEPTH + 1);
      plan_start(MODE_READ, 511);
      // single-byte read at the address extremes
      plan_start(MODE_READ, 1);
      plan[$].slave_address = 8'hFF;
      plan[$].word_address  = 8'h00;
      plan_event(EV_MODE_SELECT);
      plan_event(EV_BYTE_SENDING);
      plan_event(EV_BYTE_SENT);
      plan_event(EV_MODE_SELECT);
      plan_event(EV_RX_SELECTED);
      plan_event(EV_BYTE_RECV);
      plan[$].received_byte = 8'hFF;
      issue_plan();

      // Random transactions, noise and cut-short sequences
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= QUIET_FROM) quiet = 1'b1;
         if (!held && items_sent >= HOLD_AT) begin
            held         = 1'b1;
            hold_request = 1'b1;
         end
         if (!drained && items_sent >= DRAIN_AT) begin
            drained = 1'b1;
            drain_results();
         end
         pick = $urandom_range(0, 99);
         if (first_random) begin
            first_random = 1'b0;
            plan_read(MAX_READ_LEN);
         end else if (pick < 40) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, MAX_READ_LEN)
                                                : $urandom_range(1, PAGE_DEPTH);
            plan_read(len);
         end else if (pick < 75) begin
            plan_write($urandom_range(1, PAGE_DEPTH));
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 4)) begin
               it = rand_item(2'($urandom), 3'($urandom));
               plan.push_back(it);
            end
         end else if (pick < 95) begin
            plan_start(MODE_READ, ($urandom_range(0, 1) == 0) ? 0
                                  : $urandom_range(MAX_READ_LEN + 1, 511));
         end else begin
            plan_start(MODE_WRITE, ($urandom_range(0, 1) == 0) ? 0
                                   : $urandom_range(PAGE_DEPTH + 1, 511));
         end
         // sometimes a transaction is abandoned part way
         if (pick < 75 && plan.size() > 1 && $urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, plan.size() - 1)) void'(plan.pop_back());
         end
         issue_plan();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d request items and %0d checked command sets,",
               items_sent, sb.checked);
      $display("with %0d finished transactions and %0d rejected lengths.",
               sb.finished, sb.rejected);
      if (sb.errors == 0 && sb.expected_cmds.size() == 0) begin
         $display("i2c_eeprom_transaction_sequencer_unit verification clean");
      end else begin
         $display("i2c_eeprom_transaction_sequencer_unit verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/i2cees_pkg.sv
design/i2cees_if.sv
design/i2cees_in_stage.sv
design/i2cees_core.sv
design/i2c_eeprom_transaction_sequencer_unit.sv
design/i2cees_checker.sv
tb/sv/tb_top.sv
